// ===== rtl/prdt_pkg.sv =====
`timescale 1ns / 1ps

package prdt_pkg;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PULSE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_EN_TRACK    = 3'd0;
    localparam logic [2:0] CFG_STOP_THR    = 3'd1;
    localparam logic [2:0] CFG_TRIM_GAIN   = 3'd2;
    localparam logic [2:0] CFG_EN_METRO    = 3'd3;
    localparam logic [2:0] CFG_METRO_IVL   = 3'd4;
    localparam logic [2:0] CFG_EN_SMOOTH   = 3'd5;
    localparam logic [2:0] CFG_SMOOTH_LEN  = 3'd6;

    // Field widths
    localparam int LEVEL_W  = 21;
    localparam int SCALED_W = 18;
    localparam int ENTRY_W  = 13;
    localparam int SUM_W    = 18;
    localparam int TIME_W   = 32;

    // Serial divider and multiplier sizes
    localparam int DVD_W     = 31;
    localparam int DVS_W     = 10;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = 11;
    localparam int PROD_W    = 29;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Level constants, 8 fraction bits
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX  = 21'sd256000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN  = -21'sd1024000;
    localparam logic signed [LEVEL_W-1:0] STOP_LEVEL = 21'sd3;
    localparam logic signed [ENTRY_W-1:0] ENTRY_MIN  = -13'sd4000;
    localparam logic [SCALED_W-1:0]       SCALED_MAX = 18'd196608;
    localparam logic [DVS_W-1:0]          SCALE_DIV  = 10'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PDIV,
        ST_TRACK,
        ST_SUM,
        ST_SDIV,
        ST_SDIV_W,
        ST_SCALE,
        ST_MUL_W,
        ST_QDIV_W,
        ST_OUT
    } prdt_state_t;

endpackage

// ===== rtl/prdt_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module prdt_div
    import prdt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0]     q_reg, q_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, q_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/prdt_mul.sv =====
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, MSB first
module prdt_mul
    import prdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg, b_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                     + (b_reg[MUL_B_W-1] ? PROD_W'(a_reg) : '0);
            b_next   = {b_reg[MUL_B_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/prdt_ring.sv =====
`timescale 1ns / 1ps

// Smoothing ring: one write port, one registered read port.
// Entries never written read as zero.
module prdt_ring
    import prdt_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_idx,
    input  logic signed [ENTRY_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_idx,
    output logic signed [ENTRY_W-1:0] rd_data
);

    logic signed [ENTRY_W-1:0] mem [DEPTH];
    logic signed [ENTRY_W-1:0] rd_q_reg;
    logic [DEPTH-1:0]          valid_reg;
    logic                      rd_vld_reg;

    // Storage and read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    // Per-entry valid bits give the cleared state right out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

// ===== rtl/pulse_rate_decay_tracker.sv =====
`timescale 1ns / 1ps
// Divisions run on the shared serial divider (pulse level, ring average, output scaling);
// scaling adds a serial multiply, and smoothing adds ring reads and divider setup. Throughput:
// one request at a time; the next is taken in the cycle after the result is loaded, later while
// res_stall holds.
// Reset (rst_n, async, low) clears control, tracker and configuration registers; ring entries
// read zero through valid bits.
module pulse_rate_decay_tracker
    import prdt_pkg::*;
#(
    parameter int RING_DEPTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic                       command,
    input  logic [TIME_W-1:0]          now_ms,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic signed [LEVEL_W-1:0]  level,
    output logic [SCALED_W-1:0]        scaled_level,
    output logic                       stopped,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [10:0]                cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = $clog2(RING_DEPTH + 1);

    prdt_state_t state_reg, state_next;

    // Configuration
    logic        en_track_reg;
    logic [9:0]  stop_thr_reg;
    logic [10:0] trim_reg;
    logic        en_metro_reg;
    logic [10:0] metro_ivl_reg;
    logic        en_smooth_reg;
    logic [4:0]  smooth_len_reg;

    // Request and tracker state
    logic                       cmd_reg;
    logic [TIME_W-1:0]          now_reg;
    logic signed [LEVEL_W-1:0]  level_reg, level_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic [TIME_W-1:0]          last_pulse_reg, last_pulse_next;
    logic [TIME_W-1:0]          last_decay_reg, last_decay_next;
    logic [TIME_W-1:0]          last_metro_reg, last_metro_next;
    logic                       stop_reg, stop_next;
    logic                       neg_reg, neg_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic [PW-1:0]              cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic [SCALED_W-1:0]        scaled_reg, scaled_next;

    // Result register
    logic                       res_valid_reg, res_valid_next;
    logic signed [LEVEL_W-1:0]  res_level_reg;
    logic [SCALED_W-1:0]        res_scaled_reg;
    logic                       res_stopped_reg;
    logic                       out_free;
    logic                       res_load;

    // Derived values
    logic [9:0]                 thr_eff;
    logic [4:0]                 sl_eff;
    logic [PW-1:0]              len_eff;
    logic [TIME_W-1:0]          gap_ms;
    logic [TIME_W-1:0]          elapsed;
    logic [12:0]                thr5;
    logic                       gap_over5;
    logic signed [13:0]         d_s;
    logic [13:0]                dabs14;
    logic [11:0]                dabs;
    logic [21:0]                dabs1000;
    logic                       metro_fire;
    logic                       pulse_now;
    logic                       stop_hit;
    logic                       level_pos;
    logic [17:0]                dec_sub;
    logic [17:0]                dec_v;
    logic [LEVEL_W-1:0]         qmag;
    logic [ENTRY_W-1:0]         ent_mag;
    logic                       sum_issue;

    // Ring push
    logic                       push_en;
    logic signed [ENTRY_W-1:0]  push_data;
    logic [PW-1:0]              pos_base;
    logic signed [ENTRY_W-1:0]  rd_data;

    // Shared units
    logic                       div_start, div_busy, div_done;
    logic [DVD_W-1:0]           div_dvd, div_q;
    logic [DVS_W-1:0]           div_dvs;
    logic                       mul_start, mul_done;
    logic [PROD_W-1:0]          mul_prod;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !res_valid_reg || !res_stall;

    // Register value fixes and effective ring length
    always_comb
    begin
        thr_eff = (stop_thr_reg == '0) ? 10'd1 : stop_thr_reg;
        sl_eff  = (smooth_len_reg == '0) ? 5'd1 : smooth_len_reg;
        if (int'(sl_eff) > RING_DEPTH)
        begin
            len_eff = PW'(RING_DEPTH);
        end
        else
        begin
            len_eff = PW'(sl_eff);
        end
    end

    // Time differences and pulse level dividend
    always_comb
    begin
        gap_ms     = now_reg - last_pulse_reg;
        elapsed    = now_reg - last_decay_reg;
        thr5       = ({3'b000, thr_eff} << 2) + {3'b000, thr_eff};
        gap_over5  = (gap_ms[31:13] != '0) || (gap_ms[12:0] > thr5);
        d_s        = signed'({4'b0000, thr_eff}) - signed'({1'b0, gap_ms[12:0]});
        dabs14     = d_s[13] ? 14'(-d_s) : 14'(d_s);
        dabs       = dabs14[11:0];
        dabs1000   = {dabs, 10'b0} - {6'b0, dabs, 4'b0} - {7'b0, dabs, 3'b0};
        metro_fire = en_metro_reg && ((now_reg - last_metro_reg) > {21'b0, metro_ivl_reg});
        pulse_now  = (cmd_reg == CMD_PULSE) || metro_fire;
        stop_hit   = gap_ms > {22'b0, thr_eff};
        level_pos  = !level_reg[LEVEL_W-1] && (level_reg != '0);
        dec_sub    = {elapsed[9:0], 8'b0};
        if ((elapsed[31:10] == '0) && (level_reg[17:0] >= dec_sub))
        begin
            dec_v = level_reg[17:0] - dec_sub;
        end
        else
        begin
            dec_v = '0;
        end
        qmag      = div_q[LEVEL_W-1:0];
        ent_mag   = div_q[LEVEL_W-1:8];
        sum_issue = (cnt_reg < len_eff);
        pos_base  = (pos_reg >= len_eff) ? '0 : pos_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!pulse_now)
                begin
                    state_next = ST_TRACK;
                end
                else if (stop_reg || gap_over5)
                begin
                    state_next = (cmd_reg == CMD_PULSE) ? ST_SCALE : ST_TRACK;
                end
                else
                begin
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    state_next = (cmd_reg == CMD_PULSE) ? ST_SCALE : ST_TRACK;
                end
            end
            ST_TRACK:
            begin
                state_next = (en_track_reg && en_smooth_reg) ? ST_SUM : ST_SCALE;
            end
            ST_SUM:
            begin
                if (!sum_issue && !pend_reg)
                begin
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                state_next = acc_reg[SUM_W-1] ? ST_SCALE : ST_SDIV_W;
            end
            ST_SDIV_W:
            begin
                if (div_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = level_pos ? ST_MUL_W : ST_OUT;
            end
            ST_MUL_W:
            begin
                if (mul_done)
                begin
                    state_next = ST_QDIV_W;
                end
            end
            ST_QDIV_W:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and unit controls
    always_comb
    begin
        level_next      = level_reg;
        last_pulse_next = last_pulse_reg;
        last_decay_next = last_decay_reg;
        last_metro_next = last_metro_reg;
        stop_next       = stop_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        scaled_next     = scaled_reg;
        push_en         = 1'b0;
        push_data       = '0;
        div_start       = 1'b0;
        div_dvd         = '0;
        div_dvs         = SCALE_DIV;
        mul_start       = 1'b0;
        res_load        = 1'b0;
        unique case (state_reg)
            ST_EVAL:
            begin
                if (pulse_now)
                begin
                    last_pulse_next = now_reg;
                    if (cmd_reg == CMD_TICK)
                    begin
                        last_metro_next = now_reg;
                    end
                    if (stop_reg)
                    begin
                        stop_next = 1'b0;
                    end
                    else if (gap_over5)
                    begin
                        level_next = LEVEL_MIN;
                        push_en    = 1'b1;
                        push_data  = ENTRY_MIN;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_dvd   = {1'b0, dabs1000, 8'b0};
                        div_dvs   = thr_eff;
                        neg_next  = d_s[13];
                    end
                end
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    level_next = neg_reg ? LEVEL_W'(-qmag) : signed'(qmag);
                    push_en    = 1'b1;
                    push_data  = neg_reg ? ENTRY_W'(-ent_mag) : signed'(ent_mag);
                end
            end
            ST_TRACK:
            begin
                acc_next = '0;
                cnt_next = '0;
                if (en_track_reg)
                begin
                    last_decay_next = now_reg;
                    if (level_pos)
                    begin
                        if (stop_hit)
                        begin
                            level_next = STOP_LEVEL;
                            stop_next  = 1'b1;
                        end
                        else
                        begin
                            level_next = signed'(LEVEL_W'(dec_v));
                            push_en    = 1'b1;
                            push_data  = signed'({3'b000, dec_v[17:8]});
                        end
                    end
                end
            end
            ST_SUM:
            begin
                if (sum_issue)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next = acc_reg + SUM_W'(rd_data);
                end
            end
            ST_SDIV:
            begin
                if (acc_reg[SUM_W-1])
                begin
                    level_next = '0;
                end
                else
                begin
                    div_start = 1'b1;
                    div_dvd   = {13'b0, acc_reg};
                    div_dvs   = DVS_W'(len_eff);
                end
            end
            ST_SDIV_W:
            begin
                if (div_done)
                begin
                    level_next = signed'({div_q[12:0], 8'b0});
                end
            end
            ST_SCALE:
            begin
                if (level_pos)
                begin
                    mul_start = 1'b1;
                end
                else
                begin
                    scaled_next = '0;
                end
            end
            ST_MUL_W:
            begin
                if (mul_done)
                begin
                    div_start = 1'b1;
                    div_dvd   = {2'b00, mul_prod};
                    div_dvs   = SCALE_DIV;
                end
            end
            ST_QDIV_W:
            begin
                if (div_done)
                begin
                    if (div_q > {13'b0, SCALED_MAX})
                    begin
                        scaled_next = SCALED_MAX;
                    end
                    else
                    begin
                        scaled_next = div_q[SCALED_W-1:0];
                    end
                end
            end
            ST_OUT:
            begin
                res_load = out_free;
            end
            ST_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Ring position wraps to zero on the next push once it reaches or passes the effective length
    assign pos_next = push_en ? (pos_base + 1'b1) : pos_reg;

    // Result valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= command;
            now_reg <= now_ms;
        end
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        scaled_reg <= scaled_next;
        if (res_load)
        begin
            res_level_reg   <= level_reg;
            res_scaled_reg  <= scaled_reg;
            res_stopped_reg <= stop_reg;
        end
    end

    // Control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            pos_reg        <= '0;
            last_pulse_reg <= '0;
            last_decay_reg <= '0;
            last_metro_reg <= '0;
            stop_reg       <= 1'b0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            pos_reg        <= pos_next;
            last_pulse_reg <= last_pulse_next;
            last_decay_reg <= last_decay_next;
            last_metro_reg <= last_metro_next;
            stop_reg       <= stop_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_track_reg   <= 1'b0;
            stop_thr_reg   <= 10'd500;
            trim_reg       <= 11'd256;
            en_metro_reg   <= 1'b0;
            metro_ivl_reg  <= 11'd100;
            en_smooth_reg  <= 1'b0;
            smooth_len_reg <= 5'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EN_TRACK:   en_track_reg   <= cfg_data[0];
                CFG_STOP_THR:   stop_thr_reg   <= cfg_data[9:0];
                CFG_TRIM_GAIN:  trim_reg       <= cfg_data;
                CFG_EN_METRO:   en_metro_reg   <= cfg_data[0];
                CFG_METRO_IVL:  metro_ivl_reg  <= cfg_data;
                CFG_EN_SMOOTH:  en_smooth_reg  <= cfg_data[0];
                CFG_SMOOTH_LEN: smooth_len_reg <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    prdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    prdt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (level_reg[MUL_A_W-1:0]),
        .b     (trim_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    prdt_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_en),
        .wr_idx  (pos_base[AW-1:0]),
        .wr_data (push_data),
        .rd_en   ((state_reg == ST_SUM) && sum_issue),
        .rd_idx  (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign res_valid    = res_valid_reg;
    assign level        = res_level_reg;
    assign scaled_level = res_scaled_reg;
    assign stopped      = res_stopped_reg;

    // Level stays inside its saturation range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg >= LEVEL_MIN) && (level_reg <= LEVEL_MAX))
        else $error("level out of range");

    // Ring position never passes the ring depth
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(RING_DEPTH))
        else $error("ring position out of range");

    // Divider is only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Multiplier finishes only while the sequencer waits for it
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL_W))
        else $error("multiplier done out of sequence");

    // Scaled result is clamped
    a_scaled_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_scaled_reg <= SCALED_MAX))
        else $error("scaled level above clamp");

endmodule

// ===== dv/pulse_rate_decay_tracker_tb.sv =====
`timescale 1ns / 1ps

module pulse_rate_decay_tracker_tb;
    import prdt_pkg::*;

    localparam int DEPTH = 32;

    logic                      clk;
    logic                      rst_n;
    logic                      cmd_valid;
    logic                      cmd_stall;
    logic                      command;
    logic [TIME_W-1:0]         now_ms;
    logic                      res_valid;
    logic                      res_stall;
    logic signed [LEVEL_W-1:0] level;
    logic [SCALED_W-1:0]       scaled_level;
    logic                      stopped;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [2:0]                cfg_index;
    logic [10:0]               cfg_data;

    pulse_rate_decay_tracker #(.RING_DEPTH(DEPTH)) DUT (.*);

    // Expected result of one request
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [SCALED_W-1:0]       scaled;
        logic                      stopped;
    } tracker_result_t;

    tracker_result_t expected_q[$];
    int error_count;

    // Shadow registers
    logic        sh_en_track;
    logic [9:0]  sh_thr;
    logic [10:0] sh_gain;
    logic        sh_en_metro;
    logic [10:0] sh_metro_ivl;
    logic        sh_en_smooth;
    logic [4:0]  sh_len;

    // Shadow state
    longint      sh_level;
    longint      sh_ring[DEPTH];
    int unsigned sh_pos;
    logic [31:0] sh_last_pulse, sh_last_decay, sh_last_metro;
    logic        sh_stop;

    // Receiver stall control
    int  hold_cycles;
    bit  stall_enable;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("pulse_rate_decay_tracker_tb: FAIL");
        $finish;
    end

    function automatic int unsigned ring_len();
        int unsigned n;
        n = (sh_len == 0) ? 1 : sh_len;
        return (n > DEPTH) ? DEPTH : n;
    endfunction

    function automatic longint thr_ms();
        return (sh_thr == 0) ? 1 : sh_thr;
    endfunction

    function automatic void ring_store();
        if (sh_pos >= ring_len())
            sh_pos = 0;
        // truncation toward zero matches SV signed division
        sh_ring[sh_pos % DEPTH] = sh_level / 256;
        sh_pos++;
    endfunction

    function automatic void apply_pulse(logic [31:0] t);
        longint gap, v;
        logic [31:0] d;
        if (sh_stop)
            sh_stop = 1'b0;
        else
        begin
            d = t - sh_last_pulse;
            gap = longint'(d);
            v = (64'sd256000 * (thr_ms() - gap)) / thr_ms();
            if (v < -1024000)
                v = -1024000;
            if (v > 256000)
                v = 256000;
            sh_level = v;
            ring_store();
        end
        sh_last_pulse = t;
    endfunction

    function automatic void apply_decay(logic [31:0] t);
        logic [31:0] d;
        longint v;
        if (sh_level > 0)
        begin
            d = t - sh_last_pulse;
            if (longint'(d) > thr_ms())
            begin
                sh_level = 3;
                sh_stop = 1'b1;
            end
            else
            begin
                d = t - sh_last_decay;
                v = sh_level - longint'(d) * 256;
                if (v < 0)
                    v = 0;
                sh_level = v;
                ring_store();
            end
        end
        sh_last_decay = t;
    endfunction

    function automatic void apply_smooth();
        longint total;
        int unsigned n;
        n = ring_len();
        total = 0;
        for (int i = 0; i < n; i++)
            total += sh_ring[i];
        total = total / longint'(n);
        if (total < 0)
            total = 0;
        sh_level = total * 256;
    endfunction

    // Predict the result of one request
    function automatic tracker_result_t predict_tracker(logic cmd, logic [31:0] t);
        tracker_result_t r;
        logic [31:0] d;
        longint prod;
        if (cmd == CMD_PULSE)
            apply_pulse(t);
        else
        begin
            d = t - sh_last_metro;
            if (sh_en_metro && d > {21'd0, sh_metro_ivl})
            begin
                apply_pulse(t);
                sh_last_metro = t;
            end
            if (sh_en_track)
            begin
                apply_decay(t);
                if (sh_en_smooth)
                    apply_smooth();
            end
        end
        prod = sh_level * longint'(sh_gain);
        if (prod <= 0)
            r.scaled = '0;
        else
        begin
            prod = prod / 1000;
            r.scaled = (prod > 196608) ? SCALED_MAX : SCALED_W'(prod);
        end
        r.level = LEVEL_W'(sh_level);
        r.stopped = sh_stop;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", level, 0);
            else
            begin
                want = expected_q.pop_front();
                if (level !== want.level)
                    report_mismatch("level", level, want.level);
                if (scaled_level !== want.scaled)
                    report_mismatch("scaled_level", scaled_level, want.scaled);
                if (stopped !== want.stopped)
                    report_mismatch("stopped", stopped, want.stopped);
            end
        end
    end

    // Receiver stall pattern, with long hold-offs on request
    always @(negedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            res_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (stall_enable)
            res_stall <= ($urandom_range(0, 3) == 0);
        else
            res_stall <= 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [10:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EN_TRACK:   sh_en_track  = val[0];
            CFG_STOP_THR:   sh_thr       = val[9:0];
            CFG_TRIM_GAIN:  sh_gain      = val;
            CFG_EN_METRO:   sh_en_metro  = val[0];
            CFG_METRO_IVL:  sh_metro_ivl = val;
            CFG_EN_SMOOTH:  sh_en_smooth = val[0];
            CFG_SMOOTH_LEN: sh_len       = val[4:0];
            default: ;
        endcase
    endtask

    // Send one request; valid stays high across back-to-back requests
    task automatic send_request(logic cmd, logic [31:0] t, bit keep);
        cmd_valid = 1'b1;
        command   = cmd;
        now_ms    = t;
        do
            @(posedge clk);
        while (cmd_stall);
        expected_q.push_back(predict_tracker(cmd, t));
        @(negedge clk);
        if (!keep)
            cmd_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic configure(bit trk, int thr, int gain, bit met, int ivl, bit smo, int len);
        wait_drained();
        write_reg(CFG_EN_TRACK, 11'(trk));
        write_reg(CFG_STOP_THR, 11'(thr));
        write_reg(CFG_TRIM_GAIN, 11'(gain));
        write_reg(CFG_EN_METRO, 11'(met));
        write_reg(CFG_METRO_IVL, 11'(ivl));
        write_reg(CFG_EN_SMOOTH, 11'(smo));
        write_reg(CFG_SMOOTH_LEN, 11'(len));
    endtask

    // Random traffic: time mostly advances a little, now and then jumps
    task automatic run_random(int count);
        int burst;
        logic [31:0] step;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0:       step = $urandom();
                1:       step = $urandom_range(500, 3000);
                default: step = $urandom_range(0, 120);
            endcase
            clock_ms = clock_ms + step;
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                burst = $urandom_range(1, 12);
            end
            burst--;
            send_request(($urandom_range(0, 2) == 0) ? CMD_PULSE : CMD_TICK, clock_ms,
                         burst != 0 && i != count - 1);
        end
    endtask

    task automatic test_directed();
        logic [31:0] t;
        send_request(CMD_TICK, 32'd0, 0);
        send_request(CMD_PULSE, 32'd0, 0);
        send_request(CMD_PULSE, 32'hFFFF_FFFF, 0);
        send_request(CMD_PULSE, 32'hFFFF_FFFF, 0);
        configure(1, 1000, 1280, 1, 1, 1, 30);
        t = 32'hFFFF_FF00;
        send_request(CMD_PULSE, t, 0);
        send_request(CMD_PULSE, t + 100, 0);
        send_request(CMD_TICK, t + 150, 0);
        send_request(CMD_TICK, t + 400, 0);
        send_request(CMD_TICK, t + 2400, 0);
        send_request(CMD_PULSE, t + 2500, 0);
        send_request(CMD_PULSE, t + 2600, 0);
        send_request(CMD_TICK, t + 2601, 0);
        configure(1, 0, 0, 1, 2000, 1, 0);
        send_request(CMD_PULSE, 32'd10, 0);
        send_request(CMD_PULSE, 32'd10, 0);
        send_request(CMD_TICK, 32'd11, 0);
        send_request(CMD_TICK, 32'd3000, 0);
        configure(1, 1023, 2047, 1, 2047, 1, 31);
        send_request(CMD_PULSE, 32'd4000, 0);
        send_request(CMD_PULSE, 32'd4100, 0);
        send_request(CMD_TICK, 32'd4110, 0);
        send_request(CMD_TICK, 32'd9000, 0);
        clock_ms = 32'd9000;
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++)
        begin
            configure($urandom_range(0, 4) != 0, $urandom_range(1, 1000),
                      $urandom_range(0, 1280), $urandom_range(0, 1),
                      $urandom_range(1, 2000), $urandom_range(0, 1),
                      $urandom_range(1, 30));
            run_random(250);
        end
        // extremes of the randomized setting ranges
        configure(1, 1, 0, 1, 1, 1, 1);
        run_random(100);
        configure(1, 1000, 1280, 0, 2000, 0, 30);
        run_random(100);
    endtask

    task automatic test_backpressure();
        configure(1, 300, 512, 1, 50, 1, 8);
        hold_cycles = 600;
        run_random(40);
        // sender waits for everything outstanding
        wait_drained();
        run_random(40);
    endtask

    initial
    begin
        error_count  = 0;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        command      = CMD_TICK;
        now_ms       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_EN_TRACK;
        cfg_data     = '0;
        res_stall    = 1'b0;
        hold_cycles  = 0;
        stall_enable = 1'b1;
        clock_ms     = '0;
        sh_en_track = 0; sh_thr = 500; sh_gain = 256; sh_en_metro = 0;
        sh_metro_ivl = 100; sh_en_smooth = 0; sh_len = 5;
        sh_level = 0; sh_pos = 0; sh_stop = 0;
        sh_last_pulse = 0; sh_last_decay = 0; sh_last_metro = 0;
        for (int i = 0; i < DEPTH; i++)
            sh_ring[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_settings();
        test_backpressure();

        wait_drained();
        if (error_count == 0)
            $display("pulse_rate_decay_tracker_tb: PASS");
        else
            $display("pulse_rate_decay_tracker_tb: FAIL");
        $finish;
    end

endmodule
